### rtl/core/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the world-to-screen projection block.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int COEF_W   = 32;
  localparam int POS_W    = 32;
  localparam int SIZE_W   = 15;
  localparam int SCREEN_W = 32;
  localparam int CIDX_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH   = 4;
  localparam int QLVL_W   = $clog2(QDEPTH + 1);

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_PROJECT = 1'b1
  } wsp_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_WIDTH  = 2'd0,
    CFG_WINDOW_HEIGHT = 2'd1,
    CFG_LAYOUT_MODE   = 2'd2
  } wsp_cfg_idx_t;

  typedef struct packed {
    logic              empty;
    logic [QLVL_W-1:0] level;
  } wsp_qstat_t;

endpackage

### rtl/core/wsp_queue.sv
// ----------------------------------------------------------------------------
// wsp_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module wsp_queue #(
  parameter int DATA_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DATA_W-1:0]   din,
  input  logic                pop,
  output logic [DATA_W-1:0]   dout,
  output wsp_pkg::wsp_qstat_t stat
);
  import wsp_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  logic [DATA_W-1:0] mem_r [0:QDEPTH-1];
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [QLVL_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign dout   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QLVL_W'(push) - QLVL_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  assign stat.empty = (cnt_r == '0);
  assign stat.level = cnt_r;

endmodule

### rtl/core/wsp_front.sv
// ----------------------------------------------------------------------------
// wsp_front
// Accepts requests, keeps the matrix, computes clip x, y and w.
// ----------------------------------------------------------------------------
module wsp_front #(
  parameter int FRAC_BITS = 16,
  parameter int CW        = 67 - FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [wsp_pkg::CIDX_W-1:0]   in_coef_index,
  input  logic signed [wsp_pkg::COEF_W-1:0] in_coef_value,
  input  logic signed [wsp_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [wsp_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [wsp_pkg::POS_W-1:0]  in_pos_z,
  input  logic                         layout_mode,
  input  wsp_pkg::wsp_qstat_t          qstat,
  output logic                         push,
  output logic [3*CW-1:0]              push_data
);
  import wsp_pkg::*;

  localparam int PW = 2 * COEF_W;
  localparam int SW = PW + 2;

  logic signed [COEF_W-1:0] coef_r [0:15];
  logic signed [POS_W-1:0]  pos [0:2];
  logic signed [PW-1:0]     prod_r [0:2][0:2];
  logic signed [COEF_W-1:0] trans_r [0:2];
  logic signed [CW-1:0]     clip_r [0:2];
  logic                     va_r, vb_r;
  logic                     acc;
  logic [QLVL_W+1:0]        used;

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  assign used     = (QLVL_W+2)'(qstat.level) + (QLVL_W+2)'(va_r) + (QLVL_W+2)'(vb_r);
  assign in_stall = (used >= (QLVL_W+2)'(QDEPTH));
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        coef_r[i] <= '0;
      end
    end else if (acc && wsp_action_t'(in_action) == ACT_LOAD) begin
      coef_r[in_coef_index] <= in_coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= acc && wsp_action_t'(in_action) == ACT_PROJECT;
      vb_r <= va_r;
    end
  end

  // clip rows x, y and w are matrix rows 0, 1 and 3
  for (genvar ri = 0; ri < 3; ri++) begin : g_row
    localparam int ROW = (ri == 2) ? 3 : ri;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_sh;

    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [COEF_W-1:0] cf;
      assign cf = layout_mode ? coef_r[ROW*4 + c] : coef_r[c*4 + ROW];
      always_ff @(posedge clk) begin
        prod_r[ri][c] <= pos[c] * cf;
      end
    end

    always_ff @(posedge clk) begin
      trans_r[ri] <= layout_mode ? coef_r[ROW*4 + 3] : coef_r[12 + ROW];
    end

    assign sum    = SW'(prod_r[ri][0]) + SW'(prod_r[ri][1]) + SW'(prod_r[ri][2]);
    assign sum_sh = sum >>> FRAC_BITS;

    always_ff @(posedge clk) begin
      clip_r[ri] <= CW'(sum_sh) + CW'(trans_r[ri]);
    end
  end

  assign push      = vb_r;
  assign push_data = {clip_r[0], clip_r[1], clip_r[2]};

endmodule

### rtl/core/wsp_axis.sv
// ----------------------------------------------------------------------------
// wsp_axis
// Viewport mapping of one axis: scale, pipelined divide, round, saturate.
// ----------------------------------------------------------------------------
module wsp_axis #(
  parameter int FRAC_BITS = 16,
  parameter int CW        = 67 - FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [CW:0]                 num,
  input  logic [CW-1:0]                      w,
  input  logic [wsp_pkg::SIZE_W-1:0]         size,
  output logic [wsp_pkg::SCREEN_W-1:0]       res
);
  import wsp_pkg::*;

  localparam int NW = CW + 1;
  localparam int PW = NW + SIZE_W;
  localparam int XW = PW + FRAC_BITS + 1;
  localparam int HW = XW - 32;
  localparam int MW = (HW > CW) ? HW : CW;
  localparam int NSTG = 32;

  logic              neg1_r;
  logic [NW-1:0]     mag1_r;
  logic [CW-1:0]     w1_r, w2_r;
  logic              neg2_r, neg3_r;
  logic [PW-1:0]     prod2_r;
  logic [XW-1:0]     x3_r;
  logic [CW-1:0]     d3_r;
  logic [HW-1:0]     hi;
  logic [SCREEN_W-1:0] res_r, res_nxt;

  logic [CW-1:0]     r_r   [0:NSTG];
  logic [31:0]       q_r   [0:NSTG];
  logic [31:0]       lo_r  [0:NSTG];
  logic [CW-1:0]     d_r   [0:NSTG];
  logic              neg_r [0:NSTG];
  logic              big_r [0:NSTG];

  assign hi = x3_r[XW-1:32];

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= num[NW-1];
      mag1_r  <= num[NW-1] ? (~num + 1'b1) : num;
      w1_r    <= w;
      prod2_r <= PW'(mag1_r) * PW'(size);
      w2_r    <= w1_r;
      neg2_r  <= neg1_r;
      x3_r    <= XW'({prod2_r, {FRAC_BITS{1'b0}}}) + XW'(w2_r);
      d3_r    <= {w2_r[CW-2:0], 1'b0};
      neg3_r  <= neg2_r;
      big_r[0] <= MW'(hi) >= MW'(d3_r);
      r_r[0]   <= (MW'(hi) >= MW'(d3_r)) ? '0 : CW'(hi);
      q_r[0]   <= '0;
      lo_r[0]  <= x3_r[31:0];
      d_r[0]   <= d3_r;
      neg_r[0] <= neg3_r;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    logic [CW:0] t;
    logic        ge;
    assign t  = {r_r[k], lo_r[k][31]};
    assign ge = t >= {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= ge ? CW'(t - {1'b0, d_r[k]}) : CW'(t);
        q_r[k+1]   <= {q_r[k][30:0], ge};
        lo_r[k+1]  <= {lo_r[k][30:0], 1'b0};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  always_comb begin
    if (neg_r[NSTG]) begin
      if (big_r[NSTG] || q_r[NSTG] > 32'h8000_0000) begin
        res_nxt = 32'h8000_0000;
      end else begin
        res_nxt = ~q_r[NSTG] + 1'b1;
      end
    end else begin
      if (big_r[NSTG] || q_r[NSTG][31]) begin
        res_nxt = 32'h7FFF_FFFF;
      end else begin
        res_nxt = q_r[NSTG];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### rtl/core/wsp_back.sv
// ----------------------------------------------------------------------------
// wsp_back
// Visibility test and viewport mapping pipeline with output stage.
// ----------------------------------------------------------------------------
module wsp_back #(
  parameter int FRAC_BITS = 16,
  parameter int CW        = 67 - FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wsp_pkg::wsp_qstat_t           qstat,
  input  logic [3*CW-1:0]               pop_data,
  output logic                          pop,
  input  logic [wsp_pkg::SIZE_W-1:0]    window_width,
  input  logic [wsp_pkg::SIZE_W-1:0]    window_height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_visible,
  output logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_x,
  output logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_y
);
  import wsp_pkg::*;

  localparam int NSTAGE = 38;
  localparam logic signed [CW+3:0] VIS_MIN = (CW+4)'(1) <<< FRAC_BITS;

  logic signed [CW-1:0] cx, cy, cw;
  logic signed [CW+3:0] w10;
  logic signed [CW:0]   nx_r, ny_r;
  logic [CW-1:0]        w_r;
  logic                 vld_r [0:NSTAGE-1];
  logic                 vis_r [0:NSTAGE-1];
  logic                 en;
  logic [SCREEN_W-1:0]  rx, ry;

  assign {cx, cy, cw} = pop_data;
  assign en  = !vld_r[NSTAGE-1] || !out_stall;
  assign pop = en && !qstat.empty;
  assign w10 = ((CW+4)'(cw) <<< 3) + ((CW+4)'(cw) <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTAGE; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= !qstat.empty;
      for (int i = 1; i < NSTAGE; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r[0] <= w10 >= VIS_MIN;
      for (int i = 1; i < NSTAGE; i++) begin
        vis_r[i] <= vis_r[i-1];
      end
      nx_r <= (CW+1)'(cx) + (CW+1)'(cw);
      ny_r <= (CW+1)'(cw) - (CW+1)'(cy);
      w_r  <= cw;
    end
  end

  wsp_axis #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_x (
    .clk  (clk),
    .en   (en),
    .num  (nx_r),
    .w    (w_r),
    .size (window_width),
    .res  (rx)
  );

  wsp_axis #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_axis_y (
    .clk  (clk),
    .en   (en),
    .num  (ny_r),
    .w    (w_r),
    .size (window_height),
    .res  (ry)
  );

  assign out_valid    = vld_r[NSTAGE-1];
  assign out_visible  = vis_r[NSTAGE-1];
  assign out_screen_x = vis_r[NSTAGE-1] ? rx : '0;
  assign out_screen_y = vis_r[NSTAGE-1] ? ry : '0;

endmodule

### rtl/core/world_to_screen_projection_top.sv
// From request accept, a projection passes the front product and clip registers, the queue and the back pipeline.
// Throughput: one request per cycle while in_stall is low; loads and projects share the input.
// The per-axis 32-stage restoring divider sets the pipeline depth.
// Reset (rst_n, synchronous, active low) clears the matrix to zero, sets
// window 1920 x 1080, column-order layout, and empties queue and pipeline.
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// Matrix transform, perspective divide and viewport mapping in fixed point.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [wsp_pkg::CIDX_W-1:0]        in_coef_index,
  input  logic signed [wsp_pkg::COEF_W-1:0] in_coef_value,
  input  logic signed [wsp_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [wsp_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [wsp_pkg::POS_W-1:0]  in_pos_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_visible,
  output logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_x,
  output logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_y,
  input  logic                              cfg_we,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsp_pkg::SIZE_W-1:0]        cfg_wdata
);
  import wsp_pkg::*;

  localparam int CW = 67 - FRAC_BITS;

  logic [SIZE_W-1:0] width_r, height_r;
  logic              layout_r;
  wsp_qstat_t        qstat;
  logic              push, pop;
  logic [3*CW-1:0]   push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(1920);
      height_r <= SIZE_W'(1080);
      layout_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (wsp_cfg_idx_t'(cfg_index))
        CFG_WINDOW_WIDTH:  width_r  <= cfg_wdata;
        CFG_WINDOW_HEIGHT: height_r <= cfg_wdata;
        CFG_LAYOUT_MODE:   layout_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  wsp_front #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .layout_mode   (layout_r),
    .qstat         (qstat),
    .push          (push),
    .push_data     (push_data)
  );

  wsp_queue #(.DATA_W(3*CW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (pop_data),
    .stat  (qstat)
  );

  wsp_back #(.FRAC_BITS(FRAC_BITS), .CW(CW)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .qstat         (qstat),
    .pop_data      (pop_data),
    .pop           (pop),
    .window_width  (width_r),
    .window_height (height_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_visible   (out_visible),
    .out_screen_x  (out_screen_x),
    .out_screen_y  (out_screen_y)
  );

endmodule

### rtl/core/wsp_checker.sv
// ----------------------------------------------------------------------------
// wsp_props
// Port-level checks on the result channel of the projection block.
// ----------------------------------------------------------------------------
module wsp_props (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_visible,
  input logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_x,
  input logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_y
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_visible)
      && $stable(out_screen_x) && $stable(out_screen_y))
    else $error("stalled result changed");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_screen_x == 0 && out_screen_y == 0)
    else $error("hidden point with nonzero screen position");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind world_to_screen_projection_top wsp_props u_wsp_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_visible  (out_visible),
  .out_screen_x (out_screen_x),
  .out_screen_y (out_screen_y)
);

### tb/wsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_checker
// Watches the request, result and register ports of the projection block,
// keeps its own copy of the matrix and window setup, predicts each projection
// and compares every result in order against the predicted ones.
// ----------------------------------------------------------------------------
module wsp_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_action,
  input  logic [wsp_pkg::CIDX_W-1:0]          in_coef_index,
  input  logic signed [wsp_pkg::COEF_W-1:0]   in_coef_value,
  input  logic signed [wsp_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [wsp_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [wsp_pkg::POS_W-1:0]    in_pos_z,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_visible,
  input  logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_x,
  input  logic signed [wsp_pkg::SCREEN_W-1:0] out_screen_y,
  input  logic                                cfg_we,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wsp_pkg::SIZE_W-1:0]          cfg_wdata,
  output int                                  fail_count,
  output int                                  pending
);
  import wsp_pkg::*;

  typedef struct {
    logic              visible;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } screen_pt_t;

  logic signed [31:0] matrix [16];
  logic [SIZE_W-1:0]  win_w;
  logic [SIZE_W-1:0]  win_h;
  logic               row_order;
  screen_pt_t         screen_q [$];

  function automatic logic signed [67:0] clip_of(int r, logic signed [31:0] p [3]);
    logic signed [67:0] acc;
    int slot;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      slot = row_order ? (r * 4 + c) : (c * 4 + r);
      acc += 68'(p[c]) * 68'(matrix[slot]);
    end
    slot = row_order ? (r * 4 + 3) : (12 + r);
    return (acc >>> FRAC_BITS) + 68'(matrix[slot]);
  endfunction

  function automatic logic [31:0] axis_of(logic signed [67:0] num, logic [SIZE_W-1:0] size,
                                          logic signed [67:0] w);
    logic [127:0] mag;
    logic [127:0] n;
    logic [127:0] q;
    logic         neg;
    neg = num < 0;
    mag = neg ? 128'(-num) : 128'(num);
    n = ((mag * 128'(size)) << FRAC_BITS) + 128'(w);
    q = n / (128'(w) * 2);
    if (neg) begin
      if (q > 128'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return 32'(q);
  endfunction

  function automatic screen_pt_t project(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] pz);
    logic signed [31:0] p [3];
    logic signed [67:0] cx, cy, w;
    screen_pt_t         r;
    p[0] = px; p[1] = py; p[2] = pz;
    cx = clip_of(0, p);
    cy = clip_of(1, p);
    w  = clip_of(3, p);
    r.visible = 0; r.sx = 0; r.sy = 0;
    if (w * 10 >= (68'sd1 <<< FRAC_BITS)) begin
      r.visible = 1;
      r.sx = axis_of(cx + w, win_w, w);
      r.sy = axis_of(w - cy, win_h, w);
    end
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    screen_pt_t e;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) matrix[i] = 0;
      win_w = 1920;
      win_h = 1080;
      row_order = 0;
      screen_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (screen_q.size() == 0) begin
          $display("%t unexpected result vis %0d x %0d y %0d", $time,
                   out_visible, out_screen_x, out_screen_y);
          fail_count++;
        end else begin
          e = screen_q.pop_front();
          if (out_visible !== e.visible) begin
            $display("%t visible exp %0d act %0d", $time, e.visible, out_visible);
            fail_count++;
          end
          if (out_screen_x !== e.sx) begin
            $display("%t screen_x exp %0d act %0d", $time, e.sx, out_screen_x);
            fail_count++;
          end
          if (out_screen_y !== e.sy) begin
            $display("%t screen_y exp %0d act %0d", $time, e.sy, out_screen_y);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (wsp_action_t'(in_action) == ACT_LOAD) matrix[in_coef_index] = in_coef_value;
        else screen_q.push_back(project(in_pos_x, in_pos_y, in_pos_z));
      end
      if (cfg_we) begin
        case (wsp_cfg_idx_t'(cfg_index))
          CFG_WINDOW_WIDTH:  win_w = cfg_wdata;
          CFG_WINDOW_HEIGHT: win_h = cfg_wdata;
          CFG_LAYOUT_MODE:   row_order = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    pending = screen_q.size();
  end

endmodule

### tb/tb_world_to_screen_projection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_world_to_screen_projection_top
// Drives load and project requests with random gaps and output stalls across
// several window and layout settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_world_to_screen_projection_top;
  import wsp_pkg::*;

  logic                        clk = 0;
  logic                        rst_n = 0;
  logic                        in_valid = 0;
  logic                        in_stall;
  logic                        in_action = 0;
  logic [CIDX_W-1:0]           in_coef_index = 0;
  logic signed [COEF_W-1:0]    in_coef_value = 0;
  logic signed [POS_W-1:0]     in_pos_x = 0;
  logic signed [POS_W-1:0]     in_pos_y = 0;
  logic signed [POS_W-1:0]     in_pos_z = 0;
  logic                        out_valid;
  logic                        out_stall = 0;
  logic                        out_visible;
  logic signed [SCREEN_W-1:0]  out_screen_x;
  logic signed [SCREEN_W-1:0]  out_screen_y;
  logic                        cfg_we = 0;
  logic [CFG_IDX_W-1:0]        cfg_index = 0;
  logic [SIZE_W-1:0]           cfg_wdata = 0;
  int                          fail_count;
  int                          pending;
  logic                        in_took = 0;
  int                          gap_pct = 0;
  int                          stall_pct = 0;
  int                          hold_cnt = 0;
  logic                        hold_req = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  world_to_screen_projection_top dut (.*);

  wsp_checker chk (.*);

  always @(posedge clk) in_took <= in_valid && !in_stall;

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall = 1;
    end else if ($urandom_range(0, 299) == 0) begin
      hold_cnt = $urandom_range(15, 60);
      out_stall = 1;
    end else begin
      out_stall = $urandom_range(0, 99) < stall_pct;
    end
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] pick32(bit wide);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return 32'hFFFF_FFFF;
      4, 5: return wide ? $urandom : 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      default: return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
    endcase
  endfunction

  task automatic send(wsp_action_t act, logic [3:0] idx, logic [31:0] cv,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int g;
    if ($urandom_range(0, 99) < gap_pct) begin
      g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (g) @(negedge clk);
    end
    in_valid = 1;
    in_action = act;
    in_coef_index = idx;
    in_coef_value = cv;
    in_pos_x = px;
    in_pos_y = py;
    in_pos_z = pz;
    do @(negedge clk); while (!in_took);
    in_valid = 0;
    in_action = 1'($urandom);
    in_coef_index = CIDX_W'($urandom);
    in_coef_value = $urandom;
    in_pos_x = $urandom;
    in_pos_y = $urandom;
    in_pos_z = $urandom;
  endtask

  task automatic load(logic [3:0] idx, logic [31:0] cv);
    send(ACT_LOAD, idx, cv, $urandom, $urandom, $urandom);
  endtask

  task automatic proj(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send(ACT_PROJECT, 4'($urandom), $urandom, px, py, pz);
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(wsp_cfg_idx_t idx, logic [SIZE_W-1:0] val);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic load_matrix(bit row_order);
    logic [31:0] cv;
    for (int i = 0; i < 16; i++) begin
      cv = pick32($urandom_range(0, 3) == 0);
      if ((row_order && i >= 12) || (!row_order && i % 4 == 3))
        if ($urandom_range(0, 2) != 0) cv = $urandom_range(0, 32'h7F_FFFF);
      load(i[3:0], cv);
    end
  endtask

  task automatic random_phase(int n, bit row_order);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0:       load_matrix(row_order);
        1, 2:    load(4'($urandom), pick32(1'($urandom_range(0, 1))));
        default: proj(pick32(1), pick32(1), pick32(1));
      endcase
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] ws [5];
    ws = '{15'd1, 15'd16384, 15'h7FFF, 15'd640, 15'd0};

    repeat (4) @(negedge clk);
    rst_n = 1;

    // cleared matrix: w is zero, nothing visible
    proj(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    // identity with w = 1.0
    load(0, 32'h0001_0000);
    load(5, 32'h0001_0000);
    load(10, 32'h0001_0000);
    load(15, 32'h0001_0000);
    proj(0, 0, 0);
    proj(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    proj(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    proj(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
    // w just at and below the visibility threshold
    load(15, 32'h0000_199A);
    proj(0, 0, 0);
    load(15, 32'h0000_1999);
    proj(0, 0, 0);
    load(15, 32'hFFFF_0000);
    proj(32'h0001_0000, 0, 0);
    load(11, 32'h8000_0000);
    load(15, 32'h7FFF_FFFF);
    proj(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    load(3, 32'h7FFF_FFFF);
    proj(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    write_reg(CFG_WINDOW_WIDTH, 15'd0);
    write_reg(CFG_WINDOW_HEIGHT, 15'h7FFF);
    proj(32'h0002_0000, 32'hFFFE_0000, 32'h0000_0001);
    write_reg(CFG_LAYOUT_MODE, 1);
    proj(32'h0002_0000, 32'hFFFE_0000, 32'h0000_0001);

    for (int ph = 0; ph < 8; ph++) begin
      gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(10, 60);
      stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(10, 60);
      write_reg(CFG_WINDOW_WIDTH, ws[$urandom_range(0, 4)]);
      write_reg(CFG_WINDOW_HEIGHT, (ph == 7) ? 15'd1 : ws[$urandom_range(0, 4)]);
      write_reg(CFG_LAYOUT_MODE, ph[0]);
      load_matrix(ph[0]);
      if (ph == 2) begin
        gap_pct = 0;
        hold_req = 1;
      end
      random_phase(45, ph[0]);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
